### rtl/core/tls_pkg.sv
// Package for the traffic light sequencer: phase codes, register indexes,
// reset lengths, shared structs and the BCD conversion.
// No dependencies.
`default_nettype none

package tls_pkg;

  localparam int SecsW = 7;
  localparam int CharW = 8;
  localparam int BcdW  = 8;
  localparam int IdxW  = 2;
  localparam int OutW  = 16;

  localparam logic [SecsW-1:0] SecsMin = 7'd1;
  localparam logic [SecsW-1:0] SecsMax = 7'd99;

  localparam logic [SecsW-1:0] GreenSecsRst  = 7'd10;
  localparam logic [SecsW-1:0] OrangeSecsRst = 7'd10;
  localparam logic [SecsW-1:0] RedSecsRst    = 7'd20;

  // Configuration register indexes
  localparam logic [IdxW-1:0] RegGreen  = 2'd0;
  localparam logic [IdxW-1:0] RegOrange = 2'd1;
  localparam logic [IdxW-1:0] RegRed    = 2'd2;

  // Command characters
  localparam logic [CharW-1:0] CharRed    = 8'h72;  // 'r'
  localparam logic [CharW-1:0] CharOrange = 8'h6F;  // 'o'
  localparam logic [CharW-1:0] CharGreen  = 8'h67;  // 'g'

  // Input kind carried in tuser
  localparam logic FuncTick = 1'b0;
  localparam logic FuncChar = 1'b1;

  typedef enum logic [1:0] {
    PH_GREEN  = 2'd0,
    PH_ORANGE = 2'd1,
    PH_RED    = 2'd2
  } phase_t;

  // Clamped phase lengths
  typedef struct packed {
    logic [SecsW-1:0] green;
    logic [SecsW-1:0] orange;
    logic [SecsW-1:0] red;
  } phase_len_t;

  // Sequencer state
  typedef struct packed {
    phase_t           phase;
    logic [SecsW-1:0] remaining;
    logic             locked;
  } tls_state_t;

  // One result item
  typedef struct packed {
    logic            invalid_key;
    logic [BcdW-1:0] display_bcd;
    logic            green_on;
    logic            orange_on;
    logic            red_on;
  } tls_result_t;

  // Two BCD digits of a value, clamped to 99; tens by multiply with 205/2048
  function automatic logic [BcdW-1:0] to_bcd(input logic [SecsW-1:0] v);
    logic [SecsW-1:0] x;
    logic [14:0]      prod;
    logic [3:0]       tens;
    logic [SecsW-1:0] ones;
    x    = (v > SecsMax) ? SecsMax : v;
    prod = {8'd0, x} * 15'd205;
    tens = prod[14:11];
    ones = x - SecsW'({3'd0, tens} * 7'd10);
    return {tens, ones[3:0]};
  endfunction

endpackage

`default_nettype wire

### rtl/core/tls_cfg.sv
// Phase length registers of the traffic light sequencer, written through
// the configuration channel and clamped to 1..99 on the way out.
// Depends on tls_pkg.
`default_nettype none

module tls_cfg
  import tls_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  output      logic             cfg_ready,
  input  wire logic [IdxW-1:0]  cfg_index,
  input  wire logic [SecsW-1:0] cfg_data,
  output      phase_len_t       lengths
);

  logic [SecsW-1:0] green_secs;
  logic [SecsW-1:0] orange_secs;
  logic [SecsW-1:0] red_secs;

  assign cfg_ready = 1'b1;

  // Write the addressed register; drop writes past the last index
  always_ff @(posedge clk) begin
    if (rst) begin
      green_secs  <= GreenSecsRst;
      orange_secs <= OrangeSecsRst;
      red_secs    <= RedSecsRst;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        RegGreen:  green_secs  <= cfg_data;
        RegOrange: orange_secs <= cfg_data;
        RegRed:    red_secs    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp a stored length into 1..99
  function automatic logic [SecsW-1:0] clamp(input logic [SecsW-1:0] v);
    logic [SecsW-1:0] r;
    r = v;
    if (v == '0) r = SecsMin;
    if (v > SecsMax) r = SecsMax;
    return r;
  endfunction

  assign lengths.green  = clamp(green_secs);
  assign lengths.orange = clamp(orange_secs);
  assign lengths.red    = clamp(red_secs);

endmodule

`default_nettype wire

### rtl/core/tls_step.sv
// Next-state and result logic of the traffic light sequencer for one
// tick or command character. Purely combinational. Depends on tls_pkg.
`default_nettype none

module tls_step
  import tls_pkg::*;
(
  input  wire logic             func,
  input  wire logic [CharW-1:0] command_char,
  input  wire phase_len_t       lengths,
  input  wire tls_state_t       state,
  output      tls_state_t       state_next,
  output      tls_result_t      result
);

  phase_t           adv_phase;
  logic [SecsW-1:0] adv_len;
  logic [SecsW-1:0] dec;
  logic             bad;

  function automatic logic [SecsW-1:0] len_of(input phase_t p, input phase_len_t l);
    logic [SecsW-1:0] r;
    unique case (p)
      PH_GREEN:  r = l.green;
      PH_ORANGE: r = l.orange;
      default:   r = l.red;
    endcase
    return r;
  endfunction

  // Follow-on phase in the green, orange, red order
  always_comb begin
    unique case (state.phase)
      PH_GREEN:  adv_phase = PH_ORANGE;
      PH_ORANGE: adv_phase = PH_RED;
      default:   adv_phase = PH_GREEN;
    endcase
    adv_len = len_of(adv_phase, lengths);
    dec     = (state.remaining != '0) ? state.remaining - 7'd1 : '0;
  end

  // Next state: tick counts down, unlocked commands override; bad keys advance
  always_comb begin
    state_next = state;
    bad        = 1'b0;
    if (func == FuncTick) begin
      if (dec == '0) begin
        state_next.phase     = adv_phase;
        state_next.remaining = adv_len;
      end else begin
        state_next.remaining = dec;
      end
    end else if (!state.locked) begin
      priority if (command_char == CharRed) begin
        state_next.phase     = PH_RED;
        state_next.remaining = lengths.red;
        state_next.locked    = 1'b1;
      end else if (command_char == CharOrange) begin
        state_next.phase     = PH_ORANGE;
        state_next.remaining = lengths.orange;
        state_next.locked    = 1'b1;
      end else if (command_char == CharGreen) begin
        state_next.phase     = PH_GREEN;
        state_next.remaining = lengths.green;
        state_next.locked    = 1'b1;
      end else begin
        bad                  = 1'b1;
        state_next.phase     = adv_phase;
        state_next.remaining = adv_len;
      end
    end
  end

  // Result: lamps and display from the state after the request
  always_comb begin
    result.red_on      = (state_next.phase == PH_RED);
    result.orange_on   = (state_next.phase == PH_ORANGE);
    result.green_on    = (state_next.phase == PH_GREEN);
    result.display_bcd = to_bcd(state_next.remaining);
    result.invalid_key = bad;
  end

endmodule

`default_nettype wire

### rtl/core/traffic_light_sequencer_top.sv
// Traffic light sequencer: input register, step logic, result register.
// Path: a request accepted into the input register moves on to the result
// register, and so onto m_tvalid, when the result register is free or drains.
// Throughput: one request per cycle; the input register keeps accepting
// while a result waits, as long as the result register drains.
// Reset: green phase, count at the green reset length, lock cleared,
// lengths back to 10/10/20 seconds, both pipeline registers empty.
`default_nettype none

module traffic_light_sequencer_top
  import tls_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output      logic             s_tready,
  input  wire logic [CharW-1:0] s_tdata,   // [7:0] command_char
  input  wire logic [0:0]       s_tuser,   // [0] func
  output      logic             m_tvalid,
  input  wire logic             m_tready,
  output      logic [OutW-1:0]  m_tdata,   // [0] red_on, [1] orange_on,
                                           // [2] green_on, [10:3] display_bcd,
                                           // [11] invalid_key, [15:12] zero
  input  wire logic             cfg_valid,
  output      logic             cfg_ready,
  input  wire logic [IdxW-1:0]  cfg_index,
  input  wire logic [SecsW-1:0] cfg_data
);

  phase_len_t       lengths;
  tls_state_t       state;
  tls_state_t       state_next;
  tls_result_t      step_result;
  tls_result_t      result;
  logic             in_valid;
  logic             in_func;
  logic [CharW-1:0] in_char;
  logic             out_load;

  tls_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .lengths   (lengths)
  );

  tls_step u_step (
    .func         (in_func),
    .command_char (in_char),
    .lengths      (lengths),
    .state        (state),
    .state_next   (state_next),
    .result       (step_result)
  );

  // Handshake: move the held request on whenever the result slot frees up
  assign out_load = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || out_load;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func <= s_tuser[0];
      in_char <= s_tdata;
    end
  end

  // Sequencer state, advanced once per processed request
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase     <= PH_GREEN;
      state.remaining <= GreenSecsRst;
      state.locked    <= 1'b0;
    end else if (out_load) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result <= step_result;
    end
  end

  assign m_tdata = {4'd0, result.invalid_key, result.display_bcd,
                    result.green_on, result.orange_on, result.red_on};

  // Exactly one lamp is lit on every result
  a_one_lamp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot(m_tdata[2:0]))
    else $error("lamp outputs not one-hot");

  // The display never shows zero seconds
  a_display_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[10:3] != 8'd0))
    else $error("display shows zero");

  // Once locked, the override lock stays set until reset
  a_lock_sticky: assert property (@(posedge clk) disable iff (rst)
    state.locked |=> state.locked)
    else $error("override lock cleared without reset");

  // An unknown key is only flagged while the block was unlocked
  a_bad_unlocked: assert property (@(posedge clk) disable iff (rst)
    (out_load && step_result.invalid_key) |-> !state.locked)
    else $error("invalid key flagged while locked");

endmodule

`default_nettype wire
